// ===== src/gpg_pkg.sv =====
package gpg_pkg;

    // Grid and table sizing
    localparam int MAX_ROWS        = 8;
    localparam int MAX_COLS        = 8;
    localparam int EXP_TABLE_DEPTH = 256;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int EXP_AW = $clog2(EXP_TABLE_DEPTH);

    // Field widths
    localparam int SIZE_W   = 4;
    localparam int SHAPE_W  = 16;
    localparam int POS_W    = 13;
    localparam int POSQ_W   = 11;
    localparam int AMP_IN_W = 16;
    localparam int AMP_W    = 15;
    localparam int IDX_W    = 6;

    // Datapath widths
    localparam int E2_W       = 2 * SHAPE_W;
    localparam int SQ_W       = 2 * POSQ_W;
    localparam int D2_W       = SQ_W + 1;
    localparam int MUL_A_W    = E2_W;
    localparam int MUL_B_W    = D2_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int GAIN_W     = 17;
    localparam int FRAC_W     = 16;
    localparam int AMP_PROD_W = AMP_W + GAIN_W;

    // t is Q40; 16.0 and above gives zero gain
    localparam int T_LIMIT_BIT = 44;

    localparam logic [AMP_PROD_W-1:0] ROUND_HALF = AMP_PROD_W'(32'h0000_8000);

    // Config port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_COLS  = 2'd1;
    localparam logic [1:0] REG_SHAPE = 2'd2;

    localparam logic [SIZE_W-1:0]  ROWS_RST  = SIZE_W'(4);
    localparam logic [SIZE_W-1:0]  COLS_RST  = SIZE_W'(4);
    localparam logic [SHAPE_W-1:0] SHAPE_RST = SHAPE_W'(2048);

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_E2,
        ST_DX,
        ST_DY,
        ST_D2,
        ST_T,
        ST_LUT,
        ST_AMP,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        MUL_E2,
        MUL_DX,
        MUL_DY,
        MUL_T,
        MUL_AMP
    } mul_sel_t;

    typedef logic [EXP_TABLE_DEPTH-1:0][GAIN_W-1:0] exp_tab_t;

    // exp(-k*16/DEPTH) in Q16; r = exp(-step) from a 13-term series in Q32
    function automatic exp_tab_t build_exp_tab();
        logic [63:0]  step;
        logic [63:0]  term;
        logic [63:0]  r;
        logic [127:0] v;
        exp_tab_t     tab;
        step = 64'((64'd1 << 36) / EXP_TABLE_DEPTH);
        term = 64'd1 << 32;
        r    = term;
        v    = 128'd1 << 32;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * step) >> 32) / 64'(n);
            if (n[0]) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            tab[k] = GAIN_W'((v + 128'h8000) >> 16);
            v      = ((v * 128'(r)) + 128'h8000_0000) >> 32;
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== src/gpg_mul.sv =====
module gpg_mul
    import gpg_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic [MUL_A_W-1:0] op_a,
    input  logic [MUL_B_W-1:0] op_b,
    output logic [PROD_W-1:0]  prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== src/gpg_gain.sv =====
module gpg_gain
    import gpg_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [PROD_W-1:0] t_in,
    output logic [GAIN_W-1:0] gain
);

    logic              out_of_range;
    logic [EXP_AW-1:0] tab_idx;
    logic [GAIN_W-1:0] gain_next;
    logic [GAIN_W-1:0] gain_reg;

    // t >= 16.0 decays to zero; otherwise top bits below the limit index the table
    assign out_of_range = |t_in[PROD_W-1:T_LIMIT_BIT];
    assign tab_idx      = t_in[T_LIMIT_BIT-1 -: EXP_AW];
    assign gain_next    = out_of_range ? '0 : EXP_TAB[tab_idx];

    always_ff @(posedge aclk) begin
        if (en) begin
            gain_reg <= gain_next;
        end
    end

    assign gain = gain_reg;

endmodule

// ===== src/gaussian_phantom_grid_core.sv =====
// Gaussian phantom-point driver for a rows x cols actuator grid.
// Input stream: one transfer is one command. s_tuser is the op (set point
// then emit, or emit from the stored point); s_tdata carries pos_x, pos_y
// (1/256 grid units) and the requested amplitude. A set clamps the point
// into the current grid and the amplitude to zero or above.
// Output stream: rows*cols transfers per command, column-major, each with
// the cell index and its drive amplitude; m_tlast marks the final cell.
// APB port: grid_rows at 0x0, grid_cols at 0x4, shape_factor at 0x8.
// Write only while the block is idle.
// Timing: all products go through one registered multiplier and one
// registered exp-table stage, stepped by the sequencer below. The first
// cell lands in the output register after the SETUP, E2, DY, D2, T, LUT,
// AMP and EMIT states, each following cell after DX, DY, D2, T, LUT, AMP
// and EMIT, plus any output stall. s_tready is high only while the
// sequencer is idle.
// Stall: a cell waits in the output register; the sequencer holds until it
// is taken. Reset returns the grid to 4x4, shape 0.5, stored point zero.
module gaussian_phantom_grid_core
    import gpg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,   // pos_x[12:0], pos_y[25:13], amplitude_in[41:26]
    input  logic [0:0]         s_tuser,   // op[0]
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,   // cell_index[5:0], cell_amplitude[20:6]
    output logic               m_tlast,   // last_cell
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // ---------------- configuration registers ----------------
    logic [SIZE_W-1:0]  rows_reg;
    logic [SIZE_W-1:0]  cols_reg;
    logic [SHAPE_W-1:0] shape_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= ROWS_RST;
            cols_reg  <= COLS_RST;
            shape_reg <= SHAPE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_ROWS:  rows_reg  <= pwdata[SIZE_W-1:0];
                REG_COLS:  cols_reg  <= pwdata[SIZE_W-1:0];
                REG_SHAPE: shape_reg <= pwdata[SHAPE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ROWS:  prdata = PDATA_W'(rows_reg);
            REG_COLS:  prdata = PDATA_W'(cols_reg);
            REG_SHAPE: prdata = PDATA_W'(shape_reg);
            default:   prdata = '0;
        endcase
    end

    // Zero size acts as 1, oversize as the maximum
    logic [SIZE_W-1:0] rows_eff;
    logic [SIZE_W-1:0] cols_eff;

    assign rows_eff = (rows_reg == '0) ? SIZE_W'(1) :
                      (rows_reg > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_reg;
    assign cols_eff = (cols_reg == '0) ? SIZE_W'(1) :
                      (cols_reg > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cols_reg;

    // ---------------- command capture ----------------
    logic                       in_op_reg;
    logic signed [POS_W-1:0]    in_px_reg;
    logic signed [POS_W-1:0]    in_py_reg;
    logic signed [AMP_IN_W-1:0] in_amp_reg;

    // ---------------- sequencer ----------------
    state_t   state_reg, state_next;
    logic     in_xfer;
    logic     out_free;
    logic     last_now;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     e2_ld, dx2_ld, d2_ld, gain_en, store_ld, cnt_clr, emit;

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [ROW_W-1:0] row_last;
    logic [COL_W-1:0] col_last;

    logic m_valid_reg, m_valid_next;

    assign in_xfer  = s_tvalid & s_tready;
    assign out_free = ~m_valid_reg | m_tready;
    assign row_last = ROW_W'(rows_eff - 1'b1);
    assign col_last = COL_W'(cols_eff - 1'b1);
    assign last_now = (row_reg == row_last) && (col_reg == col_last);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_E2;
            ST_E2:    state_next = ST_DY;
            ST_DX:    state_next = ST_DY;
            ST_DY:    state_next = ST_D2;
            ST_D2:    state_next = ST_T;
            ST_T:     state_next = ST_LUT;
            ST_LUT:   state_next = ST_AMP;
            ST_AMP:   state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = last_now ? ST_IDLE : ST_DX;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        mul_en   = 1'b0;
        mul_sel  = MUL_E2;
        e2_ld    = 1'b0;
        dx2_ld   = 1'b0;
        d2_ld    = 1'b0;
        gain_en  = 1'b0;
        store_ld = 1'b0;
        cnt_clr  = 1'b0;
        emit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SETUP: begin
                // shape^2 once per command, point stored on a set
                mul_en   = 1'b1;
                mul_sel  = MUL_E2;
                store_ld = (in_op_reg == OP_SET);
                cnt_clr  = 1'b1;
            end
            ST_E2: begin
                e2_ld   = 1'b1;
                mul_en  = 1'b1;
                mul_sel = MUL_DX;
            end
            ST_DX: begin
                mul_en  = 1'b1;
                mul_sel = MUL_DX;
            end
            ST_DY: begin
                dx2_ld  = 1'b1;
                mul_en  = 1'b1;
                mul_sel = MUL_DY;
            end
            ST_D2:    d2_ld = 1'b1;
            ST_T: begin
                mul_en  = 1'b1;
                mul_sel = MUL_T;
            end
            ST_LUT:   gain_en = 1'b1;
            ST_AMP: begin
                mul_en  = 1'b1;
                mul_sel = MUL_AMP;
            end
            ST_EMIT:  emit = out_free;
            default: ;
        endcase
    end

    // Cells run column-major, so the index is just a running count
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        idx_next = idx_reg;
        if (cnt_clr) begin
            row_next = '0;
            col_next = '0;
            idx_next = '0;
        end else if (emit) begin
            idx_next = idx_reg + 1'b1;
            if (row_reg == row_last) begin
                row_next = '0;
                col_next = col_reg + 1'b1;
            end else begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    assign m_valid_next = emit | (m_valid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ---------------- stored point ----------------
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_op_reg  <= s_tuser[0];
            in_px_reg  <= s_tdata[POS_W-1:0];
            in_py_reg  <= s_tdata[2*POS_W-1:POS_W];
            in_amp_reg <= s_tdata[2*POS_W+AMP_IN_W-1:2*POS_W];
        end
    end

    logic [POSQ_W-1:0] hi_x, hi_y;
    logic [POSQ_W-1:0] clamp_x, clamp_y;
    logic [AMP_W-1:0]  clamp_amp;

    assign hi_x = POSQ_W'({COL_W'(cols_eff - 1'b1), 8'h00});
    assign hi_y = POSQ_W'({ROW_W'(rows_eff - 1'b1), 8'h00});

    always_comb begin
        if (in_px_reg[POS_W-1]) begin
            clamp_x = '0;
        end else if (in_px_reg[POS_W-2:0] > (POS_W-1)'(hi_x)) begin
            clamp_x = hi_x;
        end else begin
            clamp_x = in_px_reg[POSQ_W-1:0];
        end
        if (in_py_reg[POS_W-1]) begin
            clamp_y = '0;
        end else if (in_py_reg[POS_W-2:0] > (POS_W-1)'(hi_y)) begin
            clamp_y = hi_y;
        end else begin
            clamp_y = in_py_reg[POSQ_W-1:0];
        end
        clamp_amp = in_amp_reg[AMP_IN_W-1] ? '0 : in_amp_reg[AMP_W-1:0];
    end

    logic [POSQ_W-1:0] stored_x_reg;
    logic [POSQ_W-1:0] stored_y_reg;
    logic [AMP_W-1:0]  stored_amp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_x_reg   <= '0;
            stored_y_reg   <= '0;
            stored_amp_reg <= '0;
        end else if (store_ld) begin
            stored_x_reg   <= clamp_x;
            stored_y_reg   <= clamp_y;
            stored_amp_reg <= clamp_amp;
        end
    end

    // ---------------- distance terms ----------------
    logic [POSQ_W-1:0] col_pos, row_pos;
    logic [POSQ_W-1:0] dx_abs, dy_abs;

    assign col_pos = POSQ_W'({col_reg, 8'h00});
    assign row_pos = POSQ_W'({row_reg, 8'h00});
    assign dx_abs  = (col_pos >= stored_x_reg) ? col_pos - stored_x_reg
                                               : stored_x_reg - col_pos;
    assign dy_abs  = (row_pos >= stored_y_reg) ? row_pos - stored_y_reg
                                               : stored_y_reg - row_pos;

    // ---------------- shared multiplier ----------------
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_prod;
    logic [GAIN_W-1:0]  gain;

    logic [E2_W-1:0] e2_reg;
    logic [SQ_W-1:0] dx2_reg;
    logic [D2_W-1:0] d2_reg;

    always_comb begin
        unique case (mul_sel)
            MUL_E2: begin
                mul_a = MUL_A_W'(shape_reg);
                mul_b = MUL_B_W'(shape_reg);
            end
            MUL_DX: begin
                mul_a = MUL_A_W'(dx_abs);
                mul_b = MUL_B_W'(dx_abs);
            end
            MUL_DY: begin
                mul_a = MUL_A_W'(dy_abs);
                mul_b = MUL_B_W'(dy_abs);
            end
            MUL_T: begin
                mul_a = e2_reg;
                mul_b = d2_reg;
            end
            MUL_AMP: begin
                mul_a = MUL_A_W'(gain);
                mul_b = MUL_B_W'(stored_amp_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    gpg_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    always_ff @(posedge aclk) begin
        if (e2_ld) begin
            e2_reg <= mul_prod[E2_W-1:0];
        end
        if (dx2_ld) begin
            dx2_reg <= mul_prod[SQ_W-1:0];
        end
        if (d2_ld) begin
            d2_reg <= D2_W'(dx2_reg) + D2_W'(mul_prod[SQ_W-1:0]);
        end
    end

    gpg_gain u_gain (
        .aclk (aclk),
        .en   (gain_en),
        .t_in (mul_prod),
        .gain (gain)
    );

    // ---------------- output register ----------------
    logic [AMP_PROD_W-1:0] amp_sum;
    logic [IDX_W-1:0]      m_idx_reg;
    logic [AMP_W-1:0]      m_amp_reg;
    logic                  m_last_reg;

    // round Q16 gain product back to amplitude scale
    assign amp_sum = mul_prod[AMP_PROD_W-1:0] + ROUND_HALF;

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_idx_reg  <= idx_reg;
            m_amp_reg  <= amp_sum[FRAC_W +: AMP_W];
            m_last_reg <= last_now;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_amp_reg, m_idx_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ===== src/gpg_checker.sv =====
module gpg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic        pready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // one command at a time
    a_busy_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after a command transfer");

    // when idle, only the final cell can still be waiting
    a_idle_pending_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast)
        else $error("idle with a non-final cell pending");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && pready)
        else $error("output valid after reset");

endmodule

bind gaussian_phantom_grid_core gpg_checker u_gpg_checker (.*);

// ===== test/gaussian_phantom_grid_core_tb.sv =====
module gaussian_phantom_grid_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gpg_pkg::*;

    // Index 3 has no register behind it; writes there must change nothing
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    // The limit is set well above the slowest legal run: up to 64 cells per
    // command, a random output stall before each, about 500 commands
    localparam int CYCLE_LIMIT  = 2_000_000;
    // Wait after the last cell before touching registers or ending the run
    localparam int SETTLE_CYCLES = 16;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_CMDS    = 40;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [AMP_W-1:0] level;
        logic             last;
    } cell_t;

    // Tracks register and stored-point state, expands every accepted command
    // into its cells and checks the cell transfers against them in order.
    class grid_scoreboard;
        logic [SIZE_W-1:0]  rows_reg;
        logic [SIZE_W-1:0]  cols_reg;
        logic [SHAPE_W-1:0] shape_reg;
        int unsigned        pt_x;
        int unsigned        pt_y;
        int unsigned        pt_amp;
        int unsigned        gain_lut[EXP_TABLE_DEPTH];
        cell_t              cells_due[$];
        int                 errors;

        function new();
            longint unsigned step_q32;
            longint unsigned term;
            longint unsigned decay;
            longint unsigned acc;
            step_q32 = (64'd1 << 36) / EXP_TABLE_DEPTH;
            term     = 64'd1 << 32;
            decay    = term;
            acc      = term;
            // exp(-step) by alternating series, then successive powers
            for (int n = 1; n <= 12; n++) begin
                term = ((term * step_q32) >> 32) / longint'(n);
                if (n % 2 == 1) begin
                    decay = decay - term;
                end else begin
                    decay = decay + term;
                end
            end
            for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
                gain_lut[k] = int'((acc + 64'h8000) >> 16);
                acc = (acc * decay + 64'h8000_0000) >> 32;
            end
            rows_reg  = ROWS_RST;
            cols_reg  = COLS_RST;
            shape_reg = SHAPE_RST;
            pt_x      = 0;
            pt_y      = 0;
            pt_amp    = 0;
            errors    = 0;
        endfunction

        function int unsigned fit_size(logic [SIZE_W-1:0] raw, int unsigned top);
            if (raw == 0) return 1;
            if (raw > top) return top;
            return raw;
        endfunction

        function int unsigned clamp_pos(logic signed [POS_W-1:0] p, int unsigned n);
            int hi;
            hi = (int'(n) - 1) * 256;
            if (p < 0) return 0;
            if (int'(p) > hi) return hi;
            return int'(p);
        endfunction

        function void write_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_ROWS:  rows_reg  = value[SIZE_W-1:0];
                REG_COLS:  cols_reg  = value[SIZE_W-1:0];
                REG_SHAPE: shape_reg = value[SHAPE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned gain_at(int unsigned col, int unsigned row);
            longint          dx;
            longint          dy;
            longint unsigned d2;
            longint unsigned e2;
            longint unsigned t;
            dx = longint'(col) * 256 - longint'(pt_x);
            dy = longint'(row) * 256 - longint'(pt_y);
            d2 = dx * dx + dy * dy;
            e2 = 64'(shape_reg) * 64'(shape_reg);
            t  = e2 * d2;
            // t is Q40: 16.0 and above is treated as full decay
            if (t >= (64'd16 << 40)) return 0;
            return gain_lut[(t * EXP_TABLE_DEPTH) >> T_LIMIT_BIT];
        endfunction

        function void note_command(logic op, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                   logic [AMP_IN_W-1:0] amp_in);
            int unsigned     rows;
            int unsigned     cols;
            int unsigned     idx;
            longint unsigned lvl;
            cell_t           c;
            rows = fit_size(rows_reg, MAX_ROWS);
            cols = fit_size(cols_reg, MAX_COLS);
            if (op == OP_SET) begin
                pt_x   = clamp_pos($signed(x), cols);
                pt_y   = clamp_pos($signed(y), rows);
                pt_amp = ($signed(amp_in) < 0) ? 0 : amp_in[AMP_W-1:0];
            end
            // column-major order, one cell per transfer
            for (int unsigned col = 0; col < cols; col++) begin
                for (int unsigned row = 0; row < rows; row++) begin
                    idx     = col * rows + row;
                    lvl     = (64'(pt_amp) * 64'(gain_at(col, row)) + 64'h8000) >> 16;
                    c.index = IDX_W'(idx);
                    c.level = AMP_W'(lvl);
                    c.last  = (idx == rows * cols - 1);
                    cells_due.push_back(c);
                end
            end
        endfunction

        function void check_cell(logic [IDX_W-1:0] index, logic [AMP_W-1:0] level,
                                 logic last);
            cell_t want;
            if (cells_due.size() == 0) begin
                $error("unexpected cell transfer: index %0d level %0d", index, level);
                errors++;
                return;
            end
            want = cells_due.pop_front();
            if (index !== want.index) begin
                $error("cell_index expected %0d got %0d", want.index, index);
                errors++;
            end
            if (level !== want.level) begin
                $error("cell_amplitude expected %0d got %0d", want.level, level);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_cell expected %0d got %0d", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return cells_due.size();
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [47:0]        s_tdata;   // pos_x[12:0], pos_y[25:13], amplitude_in[41:26]
    logic [0:0]         s_tuser;   // op[0]
    logic               m_tvalid;
    logic               m_tready;
    logic [23:0]        m_tdata;   // cell_index[5:0], cell_amplitude[20:6]
    logic               m_tlast;   // last_cell
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    grid_scoreboard sb = new();
    bit             no_gaps = 1'b0;   // burst stretch: neither side idles
    int             cycle_count = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    gaussian_phantom_grid_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("gaussian_phantom_grid_core verification failed");
            $finish;
        end
    end

    // Setup then access; the register takes the value at the access edge
    // where pready is seen high. psel and penable drop again after each write.
    task automatic apb_write(logic [1:0] idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic write_grid(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] cols,
                              logic [SHAPE_W-1:0] shape);
        apb_write(REG_ROWS, PDATA_W'(rows));
        apb_write(REG_COLS, PDATA_W'(cols));
        apb_write(REG_SHAPE, PDATA_W'(shape));
    endtask

    // One command transfer. tvalid is only dropped when a gap is drawn, so a
    // back-to-back transfer never sees a low/high pair in one step.
    task automatic send_cmd(logic op, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                            logic [AMP_IN_W-1:0] amp_in);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, amp_in, y, x};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(op, x, y, amp_in);
    endtask

    // Hold off the sender until every cell due has been seen; the block is
    // idle afterwards, so registers may be written.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly set commands with points in and just around the grid; some
    // fully random fields so every input bit toggles.
    task automatic send_random_cmd();
        logic                op;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [AMP_IN_W-1:0] amp_in;
        int unsigned         span_x;
        int unsigned         span_y;
        span_x = (sb.fit_size(sb.cols_reg, MAX_COLS) - 1) * 256;
        span_y = (sb.fit_size(sb.rows_reg, MAX_ROWS) - 1) * 256;
        op     = ($urandom_range(0, 9) < 7) ? OP_SET : OP_EMIT;
        x      = ($urandom_range(0, 7) == 0) ? POS_W'($urandom)
                                             : POS_W'($urandom_range(0, span_x + 128) - 64);
        y      = ($urandom_range(0, 7) == 0) ? POS_W'($urandom)
                                             : POS_W'($urandom_range(0, span_y + 128) - 64);
        amp_in = ($urandom_range(0, 7) == 0) ? AMP_IN_W'($urandom)
                                             : AMP_IN_W'($urandom_range(0, 32767));
        send_cmd(op, x, y, amp_in);
    endtask

    // Grid sizes lean small to keep the run short; out-of-range sizes and
    // the shape extremes still come up regularly.
    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SIZE_W'(MAX_ROWS);
            2:       return SIZE_W'($urandom_range(9, 15));
            default: return SIZE_W'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [SHAPE_W-1:0] pick_shape();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return SHAPE_W'($urandom);
            default: return SHAPE_W'($urandom_range(256, 6144));
        endcase
    endfunction

    // Result side: random stall before each cell, checked on acceptance
    initial begin
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            sb.check_cell(m_tdata[IDX_W-1:0], m_tdata[IDX_W +: AMP_W], m_tlast);
        end
    end

    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_SET;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        aresetn  <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn  <= 1'b1;
        @(posedge aclk);

        // Reset grid: 4x4, shape 0.5, stored point all zero
        send_cmd(OP_EMIT, 13'h0000, 13'h0000, 16'h0000);
        send_cmd(OP_SET, 13'h0000, 13'h0000, 16'h7FFF);
        // most negative position and amplitude clamp to zero
        send_cmd(OP_SET, 13'h1000, 13'h1000, 16'h8000);
        // far past the grid edge clamps to the last column/row
        send_cmd(OP_SET, 13'h0FFF, 13'h0FFF, 16'h7FFF);
        send_cmd(OP_SET, 13'd384, 13'd128, 16'd20000);
        // emit ignores its data fields
        send_cmd(OP_EMIT, 13'h1FFF, 13'h1FFF, 16'hFFFF);
        send_cmd(OP_SET, 13'h1FFF, 13'h1FFF, 16'hFFFF);
        drain_results();

        // Single cell, flat gain
        write_grid(4'd1, 4'd1, 16'h0000);
        send_cmd(OP_SET, 13'd100, 13'h1FFB, 16'd12345);
        send_cmd(OP_EMIT, 13'h0000, 13'h0000, 16'h0000);
        drain_results();

        // Zero size runs as one row/column
        write_grid(4'd0, 4'd0, SHAPE_RST);
        send_cmd(OP_SET, 13'd0, 13'd0, 16'h7FFF);
        drain_results();

        // Full grid, steepest shape
        write_grid(4'd8, 4'd8, 16'hFFFF);
        send_cmd(OP_SET, 13'd1792, 13'd1792, 16'h7FFF);
        send_cmd(OP_SET, 13'd900, 13'd1000, 16'd30000);
        drain_results();

        // Oversized values run as the maximum grid
        write_grid(4'd15, 4'd9, SHAPE_RST);
        send_cmd(OP_SET, 13'h0FFF, 13'h0FFF, 16'd30000);
        drain_results();

        // Shrink the grid under a stored point that now lies outside it
        write_grid(4'd2, 4'd3, 16'd1024);
        send_cmd(OP_EMIT, 13'h0000, 13'h0000, 16'h0000);
        drain_results();

        // Write to the unmapped slot must leave the grid unchanged
        apb_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_cmd(OP_EMIT, 13'h0000, 13'h0000, 16'h0000);

        // Random phases, each with its own register setting; every third
        // phase pauses the sender mid-way until all cells are back.
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain_results();
            write_grid(pick_size(), pick_size(), pick_shape());
            no_gaps = (p % 4 == 3);
            for (int i = 0; i < PHASE_CMDS; i++) begin
                if (i == PHASE_CMDS / 2 && p % 3 == 0) begin
                    drain_results();
                end
                send_random_cmd();
            end
        end
        no_gaps = 1'b0;
        drain_results();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("gaussian_phantom_grid_core verification clean");
        end else begin
            $display("gaussian_phantom_grid_core verification failed");
        end
        $finish;
    end

endmodule
